>>> rtl/core/ldr_pkg.sv
// Shared types, constants and register codes for the lens undistortion remap block.
`timescale 1ns / 1ps

package ldr_pkg;

  localparam int FRAME_WIDTH_DEF  = 752;
  localparam int FRAME_HEIGHT_DEF = 480;

  localparam int CFG_AW  = 5;
  localparam int RECIP_W = 41;
  localparam int FOC_W   = 20;
  localparam int COEF_W  = 32;

  localparam logic signed [COEF_W-1:0] K1_RST = -32'sd304307141;
  localparam logic signed [COEF_W-1:0] K2_RST = 32'sd79412947;
  localparam logic signed [COEF_W-1:0] P1_RST = 32'sd207866;
  localparam logic signed [COEF_W-1:0] P2_RST = 32'sd18918;
  localparam logic [FOC_W-1:0] FX_RST = 20'd117415;
  localparam logic [FOC_W-1:0] FY_RST = 20'd117068;
  localparam logic [FOC_W-1:0] CX_RST = 20'd94007;
  localparam logic [FOC_W-1:0] CY_RST = 20'd63584;

  localparam logic [RECIP_W-1:0] RECIP_X_RST = RECIP_W'((64'd1 << 40) / 64'd117415);
  localparam logic [RECIP_W-1:0] RECIP_Y_RST = RECIP_W'((64'd1 << 40) / 64'd117068);

  typedef enum logic [2:0] {
    REG_K1      = 3'd0,
    REG_K2      = 3'd1,
    REG_P1      = 3'd2,
    REG_P2      = 3'd3,
    REG_FOCAL_X = 3'd4,
    REG_FOCAL_Y = 3'd5,
    REG_CENT_X  = 3'd6,
    REG_CENT_Y  = 3'd7
  } ldr_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
    logic [FOC_W-1:0]         fx;
    logic [FOC_W-1:0]         fy;
    logic [FOC_W-1:0]         cx;
    logic [FOC_W-1:0]         cy;
    logic [RECIP_W-1:0]       rx;
    logic [RECIP_W-1:0]       ry;
  } ldr_coef_t;

  typedef struct packed {
    logic       vld;
    logic       fetch;
    logic [9:0] col;
    logic [8:0] row;
    logic [7:0] pix;
  } ldr_ctl_t;

endpackage

>>> rtl/core/lens_undistort_remap.sv
// Lens undistortion remap top level: channels, config port and frame store.
//
// Input channel (in_valid/in_ready) carries one word per request: a load
// (in_req_type 0) writes in_pixel_in at (in_col, in_row) of the stored
// distorted frame; a fetch (in_req_type 1) names an undistorted pixel.
// Each fetch yields one result word on the out channel (out_valid/out_ready)
// with the source pixel and out_source_inside; loads yield nothing.
// A fetch passes the ctl_r control stages and then the result register, which is
// loaded together with the frame store read data. One word per cycle is taken
// while the pipeline moves; the mapping pipeline and the frame store port
// advance together, and a load writes at the same stage where a fetch reads,
// so requests act on the frame in arrival order. When a result waits with
// out_ready low, the pipeline holds and in_ready drops. A write to a focal
// length register starts a bit-serial reciprocal; in_ready stays low meanwhile.
// Reset (synchronous rst_n) restores the default coefficients and empties
// the pipeline; the frame store keeps no reset state and each pixel must be
// loaded before it is fetched.
`timescale 1ns / 1ps

module lens_undistort_remap #(
  parameter int FRAME_WIDTH  = ldr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ldr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [9:0]                 in_col,
  input  logic [8:0]                 in_row,
  input  logic [7:0]                 in_pixel_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pixel_out,
  output logic                       out_source_inside,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  ldr_pkg::ldr_coef_t coef;
  ldr_pkg::ldr_ctl_t  in_ctl;
  logic               cfg_busy;
  logic               adv;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [7:0]         mem_wdata;
  logic [7:0]         mem_rdata;
  logic               res_vld, res_inside;
  logic               out_valid_r, out_inside_r;

  assign pready   = 1'b1;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !cfg_busy;

  always_comb begin
    in_ctl.vld   = in_valid && in_ready;
    in_ctl.fetch = in_req_type;
    in_ctl.col   = in_col;
    in_ctl.row   = in_row;
    in_ctl.pix   = in_pixel_in;
  end

  ldr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef),
    .busy    (cfg_busy)
  );

  ldr_geom #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .AW           (AW)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_ctl     (in_ctl),
    .coef       (coef),
    .mem_addr   (mem_addr),
    .mem_we     (mem_we),
    .mem_wdata  (mem_wdata),
    .res_vld    (res_vld),
    .res_inside (res_inside)
  );

  ldr_frame #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame (
    .clk   (clk),
    .en    (adv),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_inside_r <= res_inside;
  end

  assign out_valid         = out_valid_r;
  assign out_source_inside = out_inside_r;
  assign out_pixel_out     = out_inside_r ? mem_rdata : 8'd0;

`ifndef NO_ASSERTIONS
  a_focal_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite &&
     ((paddr[4:2] == ldr_pkg::REG_FOCAL_X) || (paddr[4:2] == ldr_pkg::REG_FOCAL_Y)))
    |=> !in_ready)
    else $error("input taken while focal reciprocal in progress");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> rtl/core/ldr_recip.sv
// Bit-serial restoring divider forming floor(2^40 / f) for a focal length.
`timescale 1ns / 1ps

module ldr_recip #(
  parameter logic [ldr_pkg::RECIP_W-1:0] RST_RECIP = ldr_pkg::RECIP_X_RST
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ldr_pkg::FOC_W-1:0]   divisor,
  output logic                        busy,
  output logic [ldr_pkg::RECIP_W-1:0] recip
);

  localparam int FW = ldr_pkg::FOC_W;
  localparam int QW = ldr_pkg::RECIP_W;
  localparam logic [5:0] LAST = 6'(QW - 1);

  logic          busy_r;
  logic [5:0]    cnt_r;
  logic [FW-1:0] rem_r, rem_nxt;
  logic [FW-1:0] div_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [QW-1:0] recip_r;
  logic [FW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {rem_r, (cnt_r == 6'd0)};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? FW'(trial - {1'b0, div_r}) : trial[FW-1:0];
    q_nxt   = {q_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      recip_r <= RST_RECIP;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == LAST) begin
        busy_r  <= 1'b0;
        recip_r <= q_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= '0;
      div_r <= (divisor == '0) ? FW'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy  = busy_r;
  assign recip = recip_r;

endmodule

>>> rtl/core/ldr_cfg.sv
// Configuration register file with APB access and focal reciprocal units.
`timescale 1ns / 1ps

module ldr_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output ldr_pkg::ldr_coef_t         coef,
  output logic                       busy
);

  localparam int FW = ldr_pkg::FOC_W;

  logic signed [31:0] k1_r, k2_r, p1_r, p2_r;
  logic [FW-1:0]      fx_r, fy_r, cx_r, cy_r;
  logic               wr;
  ldr_pkg::ldr_reg_t  idx;
  logic               busy_x, busy_y;
  logic [ldr_pkg::RECIP_W-1:0] rx, ry;

  assign idx = ldr_pkg::ldr_reg_t'(paddr[4:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= ldr_pkg::K1_RST;
      k2_r <= ldr_pkg::K2_RST;
      p1_r <= ldr_pkg::P1_RST;
      p2_r <= ldr_pkg::P2_RST;
      fx_r <= ldr_pkg::FX_RST;
      fy_r <= ldr_pkg::FY_RST;
      cx_r <= ldr_pkg::CX_RST;
      cy_r <= ldr_pkg::CY_RST;
    end else if (wr) begin
      case (idx)
        ldr_pkg::REG_K1:      k1_r <= pwdata;
        ldr_pkg::REG_K2:      k2_r <= pwdata;
        ldr_pkg::REG_P1:      p1_r <= pwdata;
        ldr_pkg::REG_P2:      p2_r <= pwdata;
        ldr_pkg::REG_FOCAL_X: fx_r <= pwdata[FW-1:0];
        ldr_pkg::REG_FOCAL_Y: fy_r <= pwdata[FW-1:0];
        ldr_pkg::REG_CENT_X:  cx_r <= pwdata[FW-1:0];
        ldr_pkg::REG_CENT_Y:  cy_r <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ldr_pkg::REG_K1:      prdata = k1_r;
      ldr_pkg::REG_K2:      prdata = k2_r;
      ldr_pkg::REG_P1:      prdata = p1_r;
      ldr_pkg::REG_P2:      prdata = p2_r;
      ldr_pkg::REG_FOCAL_X: prdata = {12'd0, fx_r};
      ldr_pkg::REG_FOCAL_Y: prdata = {12'd0, fy_r};
      ldr_pkg::REG_CENT_X:  prdata = {12'd0, cx_r};
      ldr_pkg::REG_CENT_Y:  prdata = {12'd0, cy_r};
      default:              prdata = '0;
    endcase
  end

  ldr_recip #(.RST_RECIP(ldr_pkg::RECIP_X_RST)) u_recip_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (wr && (idx == ldr_pkg::REG_FOCAL_X)),
    .divisor (pwdata[FW-1:0]),
    .busy    (busy_x),
    .recip   (rx)
  );

  ldr_recip #(.RST_RECIP(ldr_pkg::RECIP_Y_RST)) u_recip_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (wr && (idx == ldr_pkg::REG_FOCAL_Y)),
    .divisor (pwdata[FW-1:0]),
    .busy    (busy_y),
    .recip   (ry)
  );

  assign busy = busy_x || busy_y;

  always_comb begin
    coef.k1 = k1_r;
    coef.k2 = k2_r;
    coef.p1 = p1_r;
    coef.p2 = p2_r;
    coef.fx = fx_r;
    coef.fy = fy_r;
    coef.cx = cx_r;
    coef.cy = cy_r;
    coef.rx = rx;
    coef.ry = ry;
  end

endmodule

>>> rtl/core/ldr_geom.sv
// Pipelined distortion mapping from output pixel to frame store address.
`timescale 1ns / 1ps

module ldr_geom #(
  parameter int FRAME_WIDTH  = ldr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ldr_pkg::FRAME_HEIGHT_DEF,
  parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ldr_pkg::ldr_ctl_t  in_ctl,
  input  ldr_pkg::ldr_coef_t coef,
  output logic [AW-1:0]      mem_addr,
  output logic               mem_we,
  output logic [7:0]         mem_wdata,
  output logic               res_vld,
  output logic               res_inside
);

  localparam int CW = $clog2(FRAME_WIDTH);
  localparam int RW = $clog2(FRAME_HEIGHT);
  localparam logic [AW-1:0] W_A  = AW'(FRAME_WIDTH);
  localparam logic [34:0] US_LIM = 35'(FRAME_WIDTH * 256);
  localparam logic [34:0] VS_LIM = 35'(FRAME_HEIGHT * 256);
  localparam logic signed [46:0] NLIM = 47'sd33554432;

  ldr_pkg::ldr_ctl_t ctl_r [1:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 15; i++) ctl_r[i].vld <= 1'b0;
    end else if (en) begin
      ctl_r[1] <= in_ctl;
      for (int i = 2; i <= 15; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  logic signed [20:0] dx_r, dy_r;
  logic signed [42:0] xlo_r, ylo_r;
  logic signed [41:0] xhi_r, yhi_r;
  logic signed [62:0] xsum, ysum;
  logic signed [46:0] xs, ys;
  logic signed [26:0] xp_r [4:10];
  logic signed [26:0] yp_r [4:10];
  logic               near_r [4:14];
  logic signed [53:0] pxx_r, pyy_r, pxy_r;
  logic [54:0]        psum;
  logic [26:0]        xx_r, yy_r;
  logic [27:0]        r2_r;
  logic signed [27:0] xy_r;
  logic [28:0]        tsx, tsy;
  logic [55:0]        r4p_r;
  logic signed [60:0] k1r2_r;
  logic signed [59:0] p1xy_r, p2xy_r;
  logic signed [61:0] p2tx_r, p1ty_r;
  logic [30:0]        r4_r;
  logic [32:0]        fa_r [8:9];
  logic [33:0]        tx_r [8:11];
  logic [33:0]        ty_r [8:11];
  logic signed [63:0] k2r4_r;
  logic [34:0]        f_r;
  logic signed [61:0] xf_r, yf_r;
  logic [37:0]        xd_r, yd_r;
  logic signed [58:0] uf_r, vf_r;
  logic [35:0]        us, vs;
  logic               ins;
  logic [CW-1:0]      sc_r;
  logic [RW-1:0]      sr_r;
  logic               ins_r;
  logic [AW-1:0]      addr_r;
  logic               we_r;
  logic               lok;

  always_comb begin
    xsum = $signed({xhi_r, 21'd0}) + $signed({{20{xlo_r[42]}}, xlo_r});
    ysum = $signed({yhi_r, 21'd0}) + $signed({{20{ylo_r[42]}}, ylo_r});
    xs   = 47'(xsum >>> 16);
    ys   = 47'(ysum >>> 16);
    psum = {1'b0, pxx_r} + {1'b0, pyy_r};
    tsx  = {1'b0, r2_r} + {1'b0, xx_r, 1'b0};
    tsy  = {1'b0, r2_r} + {1'b0, yy_r, 1'b0};
    us   = {{1{uf_r[58]}}, uf_r[58:24]} + {16'd0, coef.cx};
    vs   = {{1{vf_r[58]}}, vf_r[58:24]} + {16'd0, coef.cy};
    ins  = near_r[13] && !us[35] && !vs[35] && (us[34:0] < US_LIM) && (vs[34:0] < VS_LIM);
    lok  = (13'(ctl_r[14].col) < 13'(FRAME_WIDTH)) && (13'(ctl_r[14].row) < 13'(FRAME_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed({3'd0, ctl_r[1].col, 8'd0}) - $signed({1'b0, coef.cx});
      dy_r <= $signed({4'd0, ctl_r[1].row, 8'd0}) - $signed({1'b0, coef.cy});

      xlo_r <= dx_r * $signed({1'b0, coef.rx[20:0]});
      xhi_r <= dx_r * $signed({1'b0, coef.rx[40:21]});
      ylo_r <= dy_r * $signed({1'b0, coef.ry[20:0]});
      yhi_r <= dy_r * $signed({1'b0, coef.ry[40:21]});

      xp_r[4]   <= xs[26:0];
      yp_r[4]   <= ys[26:0];
      near_r[4] <= (xs <= NLIM) && (xs >= -NLIM) && (ys <= NLIM) && (ys >= -NLIM);
      for (int i = 5; i <= 10; i++) begin
        xp_r[i] <= xp_r[i-1];
        yp_r[i] <= yp_r[i-1];
      end
      for (int i = 5; i <= 14; i++) near_r[i] <= near_r[i-1];

      pxx_r <= xp_r[4] * xp_r[4];
      pyy_r <= yp_r[4] * yp_r[4];
      pxy_r <= xp_r[4] * yp_r[4];

      xx_r <= pxx_r[50:24];
      yy_r <= pyy_r[50:24];
      r2_r <= psum[51:24];
      xy_r <= pxy_r[51:24];

      r4p_r  <= r2_r * r2_r;
      k1r2_r <= coef.k1 * $signed({1'b0, r2_r});
      p1xy_r <= coef.p1 * xy_r;
      p2xy_r <= coef.p2 * xy_r;
      p2tx_r <= coef.p2 * $signed({1'b0, tsx});
      p1ty_r <= coef.p1 * $signed({1'b0, tsy});

      r4_r    <= r4p_r[54:24];
      fa_r[8] <= 33'd16777216 + {{2{k1r2_r[60]}}, k1r2_r[60:30]};
      tx_r[8] <= {{3{p1xy_r[59]}}, p1xy_r[59:29]} + {{2{p2tx_r[61]}}, p2tx_r[61:30]};
      ty_r[8] <= {{2{p1ty_r[61]}}, p1ty_r[61:30]} + {{3{p2xy_r[59]}}, p2xy_r[59:29]};
      fa_r[9] <= fa_r[8];
      for (int i = 9; i <= 11; i++) begin
        tx_r[i] <= tx_r[i-1];
        ty_r[i] <= ty_r[i-1];
      end

      k2r4_r <= coef.k2 * $signed({1'b0, r4_r});

      f_r <= {{2{fa_r[9][32]}}, fa_r[9]} + {{1{k2r4_r[63]}}, k2r4_r[63:30]};

      xf_r <= xp_r[10] * $signed(f_r);
      yf_r <= yp_r[10] * $signed(f_r);

      xd_r <= xf_r[61:24] + {{4{tx_r[11][33]}}, tx_r[11]};
      yd_r <= yf_r[61:24] + {{4{ty_r[11][33]}}, ty_r[11]};

      uf_r <= $signed({1'b0, coef.fx}) * $signed(xd_r);
      vf_r <= $signed({1'b0, coef.fy}) * $signed(yd_r);

      ins_r <= ins;
      sc_r  <= us[8 +: CW];
      sr_r  <= vs[8 +: RW];

      if (ctl_r[14].fetch) begin
        addr_r <= AW'(sr_r) * W_A + AW'(sc_r);
      end else begin
        addr_r <= AW'(ctl_r[14].row) * W_A + AW'(ctl_r[14].col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_r <= 1'b0;
    end else if (en) begin
      we_r <= ctl_r[14].vld && !ctl_r[14].fetch && lok;
    end
  end

  logic ins15_r;
  always_ff @(posedge clk) begin
    if (en) ins15_r <= ins_r;
  end

  assign mem_addr   = addr_r;
  assign mem_we     = we_r;
  assign mem_wdata  = ctl_r[15].pix;
  assign res_vld    = ctl_r[15].vld && ctl_r[15].fetch;
  assign res_inside = ins15_r;

endmodule

>>> rtl/core/ldr_frame.sv
// Frame store: single-port byte memory with registered read data.
`timescale 1ns / 1ps

module ldr_frame #(
  parameter int DEPTH = ldr_pkg::FRAME_WIDTH_DEF * ldr_pkg::FRAME_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> bench/lens_undistort_remap_checker.sv
// Checker for the lens undistortion remap block: predicts and compares result words.
`timescale 1ns / 1ps

module lens_undistort_remap_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [9:0]                 in_col,
  input  logic [8:0]                 in_row,
  input  logic [7:0]                 in_pixel_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [7:0]                 out_pixel_out,
  input  logic                       out_source_inside,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         pending,
  output int                         fails
);

  localparam int FW = ldr_pkg::FRAME_WIDTH_DEF;
  localparam int FH = ldr_pkg::FRAME_HEIGHT_DEF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
  } remap_word_t;

  ldr_pkg::ldr_coef_t lens;
  logic [7:0]         frame_copy [0:FW*FH-1];
  remap_word_t        remap_q [$];

  function automatic logic [ldr_pkg::RECIP_W-1:0] recip_of(logic [ldr_pkg::FOC_W-1:0] f);
    return ldr_pkg::RECIP_W'((64'd1 << 40) / ((f == 0) ? 64'd1 : 64'(f)));
  endfunction

  // {hit, source row, source column} for an undistorted pixel
  function automatic logic [19:0] source_of(logic [9:0] col, logic [8:0] row);
    longint x, y, r2, r4, gain, xy, xx, yy, xd, yd, us, vs;
    logic [19:0] res;
    res = '0;
    x = ((longint'({col, 8'b0}) - longint'(lens.cx)) * longint'(lens.rx)) >>> 16;
    y = ((longint'({row, 8'b0}) - longint'(lens.cy)) * longint'(lens.ry)) >>> 16;
    if (x <= (64'sd1 <<< 25) && x >= -(64'sd1 <<< 25) &&
        y <= (64'sd1 <<< 25) && y >= -(64'sd1 <<< 25)) begin
      r2 = (x * x + y * y) >>> 24;
      r4 = (r2 * r2) >>> 24;
      gain = (64'sd1 <<< 24) + ((longint'(lens.k1) * r2) >>> 30)
           + ((longint'(lens.k2) * r4) >>> 30);
      xy = (x * y) >>> 24;
      xx = (x * x) >>> 24;
      yy = (y * y) >>> 24;
      xd = ((x * gain) >>> 24) + ((longint'(lens.p1) * xy) >>> 29)
         + ((longint'(lens.p2) * (r2 + 2 * xx)) >>> 30);
      yd = ((y * gain) >>> 24) + ((longint'(lens.p1) * (r2 + 2 * yy)) >>> 30)
         + ((longint'(lens.p2) * xy) >>> 29);
      us = ((longint'(lens.fx) * xd) >>> 24) + longint'(lens.cx);
      vs = ((longint'(lens.fy) * yd) >>> 24) + longint'(lens.cy);
      if (us >= 0 && vs >= 0 && us < FW * 256 && vs < FH * 256)
        res = {1'b1, 9'(vs >>> 8), 10'(us >>> 8)};
    end
    return res;
  endfunction

  assign pending = remap_q.size();

  always @(posedge clk) begin
    logic [19:0] src;
    remap_word_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      lens <= '{ldr_pkg::K1_RST, ldr_pkg::K2_RST, ldr_pkg::P1_RST, ldr_pkg::P2_RST,
                ldr_pkg::FX_RST, ldr_pkg::FY_RST, ldr_pkg::CX_RST, ldr_pkg::CY_RST,
                ldr_pkg::RECIP_X_RST, ldr_pkg::RECIP_Y_RST};
      remap_q.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ldr_pkg::ldr_reg_t'(paddr[4:2]))
          ldr_pkg::REG_K1:      lens.k1 <= pwdata;
          ldr_pkg::REG_K2:      lens.k2 <= pwdata;
          ldr_pkg::REG_P1:      lens.p1 <= pwdata;
          ldr_pkg::REG_P2:      lens.p2 <= pwdata;
          ldr_pkg::REG_FOCAL_X: begin
            lens.fx <= pwdata[19:0];
            lens.rx <= recip_of(pwdata[19:0]);
          end
          ldr_pkg::REG_FOCAL_Y: begin
            lens.fy <= pwdata[19:0];
            lens.ry <= recip_of(pwdata[19:0]);
          end
          ldr_pkg::REG_CENT_X:  lens.cx <= pwdata[19:0];
          ldr_pkg::REG_CENT_Y:  lens.cy <= pwdata[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (!in_req_type) begin
          if (in_col < FW && in_row < FH)
            frame_copy[in_row * FW + in_col] = in_pixel_in;
        end else begin
          src = source_of(in_col, in_row);
          want.hit = src[19];
          want.pixel = src[19] ? frame_copy[src[18:10] * FW + src[9:0]] : 8'd0;
          remap_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (remap_q.size() == 0) begin
          $error("unexpected result word: pixel_out %0d source_inside %0d",
                 out_pixel_out, out_source_inside);
          errs++;
        end else begin
          want = remap_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
            errs++;
          end
          if (out_source_inside !== want.hit) begin
            $error("source_inside: expected %0d, got %0d", want.hit, out_source_inside);
            errs++;
          end
        end
      end
      fails <= fails + errs;
    end
  end

endmodule

>>> bench/lens_undistort_remap_tb.sv
// Testbench top for the lens undistortion remap block: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module lens_undistort_remap_tb;

  localparam int FW = ldr_pkg::FRAME_WIDTH_DEF;
  localparam int FH = ldr_pkg::FRAME_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, in_req_type = 1'b0;
  logic [9:0] in_col = '0;
  logic [8:0] in_row = '0;
  logic [7:0] in_pixel_in = '0;
  logic out_valid, out_ready = 1'b0;
  logic [7:0] out_pixel_out;
  logic out_source_inside;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [ldr_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int pending, fails;
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit loaded [0:FW*FH-1];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lens_undistort_remap u_top (.*);

  lens_undistort_remap_checker u_chk (.*);

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 25);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= !idle_now();

  task automatic send_word(logic kind, logic [9:0] col, logic [8:0] row, logic [7:0] pix);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_col <= col;
    in_row <= row;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_pixel(logic [9:0] col, logic [8:0] row, logic [7:0] pix);
    send_word(1'b0, col, row, pix);
    if (col < FW && row < FH) loaded[row * FW + col] = 1'b1;
  endtask

  // make sure the source pixel holds data before fetching through it
  task automatic fetch_pixel(logic [9:0] col, logic [8:0] row);
    logic [19:0] src;
    src = u_chk.source_of(col, row);
    if (src[19] && !loaded[src[18:10] * FW + src[9:0]])
      load_pixel(src[9:0], src[18:10], 8'($urandom));
    send_word(1'b1, col, row, 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(ldr_pkg::ldr_reg_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic lens_setup(int phase);
    case (phase)
      1: begin
        cfg_write(ldr_pkg::REG_K1, 32'h7fffffff);
        cfg_write(ldr_pkg::REG_K2, 32'h80000000);
        cfg_write(ldr_pkg::REG_P1, 32'h7fffffff);
        cfg_write(ldr_pkg::REG_P2, 32'h80000000);
      end
      2: begin
        cfg_write(ldr_pkg::REG_K1, 32'h80000000);
        cfg_write(ldr_pkg::REG_K2, 32'h7fffffff);
        cfg_write(ldr_pkg::REG_P1, 32'h80000000);
        cfg_write(ldr_pkg::REG_P2, 32'h7fffffff);
        cfg_write(ldr_pkg::REG_FOCAL_X, 32'd256);
        cfg_write(ldr_pkg::REG_FOCAL_Y, 32'd256);
      end
      3: begin
        cfg_write(ldr_pkg::REG_FOCAL_X, 32'd0);
        cfg_write(ldr_pkg::REG_FOCAL_Y, 32'd0);
        cfg_write(ldr_pkg::REG_CENT_X, 32'd0);
        cfg_write(ldr_pkg::REG_CENT_Y, 32'd0);
      end
      4: begin
        cfg_write(ldr_pkg::REG_FOCAL_X, 32'hfffff);
        cfg_write(ldr_pkg::REG_FOCAL_Y, 32'hfffff);
        cfg_write(ldr_pkg::REG_CENT_X, 32'hfffff);
        cfg_write(ldr_pkg::REG_CENT_Y, 32'hfffff);
      end
      default: begin
        cfg_write(ldr_pkg::REG_K1, 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28)));
        cfg_write(ldr_pkg::REG_K2, 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26)));
        cfg_write(ldr_pkg::REG_P1, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
        cfg_write(ldr_pkg::REG_P2, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
        cfg_write(ldr_pkg::REG_FOCAL_X, $urandom_range(40000, 200000));
        cfg_write(ldr_pkg::REG_FOCAL_Y, $urandom_range(40000, 200000));
        cfg_write(ldr_pkg::REG_CENT_X, $urandom_range(0, FW * 256));
        cfg_write(ldr_pkg::REG_CENT_Y, $urandom_range(0, FH * 256));
      end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, out-of-frame loads and fetches at the reset lens
    load_pixel(10'd0, 9'd0, 8'd0);
    load_pixel(10'd751, 9'd479, 8'd255);
    load_pixel(10'd1023, 9'd511, 8'd255);
    load_pixel(10'd752, 9'd0, 8'd170);
    load_pixel(10'd0, 9'd480, 8'd85);
    fetch_pixel(10'd0, 9'd0);
    fetch_pixel(10'd751, 9'd0);
    fetch_pixel(10'd0, 9'd479);
    fetch_pixel(10'd751, 9'd479);
    fetch_pixel(10'd367, 9'd248);
    fetch_pixel(10'd1023, 9'd511);
    fetch_pixel(10'd800, 9'd500);
    load_pixel(10'd367, 9'd248, 8'h5a);
    fetch_pixel(10'd367, 9'd248);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        settle();
        lens_setup(phase);
      end
      calm = (phase == 5);
      while (sent < 150 * (phase + 1)) begin
        if ($urandom_range(99) < 35)
          load_pixel($urandom_range(99) < 90 ? 10'($urandom_range(0, FW - 1)) : 10'($urandom),
                     $urandom_range(99) < 90 ? 9'($urandom_range(0, FH - 1)) : 9'($urandom),
                     8'($urandom));
        else if ($urandom_range(99) < 90)
          fetch_pixel(10'($urandom_range(0, FW - 1)), 9'($urandom_range(0, FH - 1)));
        else
          fetch_pixel(10'($urandom), 9'($urandom));
      end
    end
    calm = 1'b0;
    settle();

    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ldr_pkg.sv
rtl/core/ldr_recip.sv
rtl/core/ldr_cfg.sv
rtl/core/ldr_geom.sv
rtl/core/ldr_frame.sv
rtl/core/lens_undistort_remap.sv
bench/lens_undistort_remap_checker.sv
bench/lens_undistort_remap_tb.sv
